// ===== rtl/core/dau_pkg.sv =====
// Shared constants, types and the arctangent table of the dihedral angle unit.
package dau_pkg;

    // Extra fraction bits carried on the bond length and on Y.
    localparam int LEN_EXTRA = 16;
    // Significant bits kept after normalization of the atan2 arguments.
    localparam int NORM_BITS = 30;
    // Limb width of the partial-product multiplier.
    localparam int MUL_LIMB = 24;
    // Number of entries in the arctangent table.
    localparam int ATAN_LEN = 32;
    // Working widths of the rotation stages.
    localparam int UV_BITS = 33;
    localparam int Z_BITS = 34;
    // Output angle: signed Q9.16 degrees.
    localparam int ANGLE_BITS = 25;
    localparam int ANGLE_MAX = 11796480;

    // Angles in Q.24 degrees.
    localparam logic signed [Z_BITS-1:0] DEG90_Q24 = Z_BITS'(64'sd1509949440);
    localparam logic signed [Z_BITS-1:0] DEG180_Q24 = Z_BITS'(64'sd3019898880);
    localparam logic signed [Z_BITS-1:0] ROUND_HALF = Z_BITS'(64'sd128);
    localparam int ROUND_SHIFT = 8;

    // atan(2^-i) in degrees, Q.24.
    localparam logic [31:0] ATAN_Q24 [ATAN_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934, 32'd30029717, 32'd15018523, 32'd7509720,
        32'd3754917, 32'd1877466, 32'd938734, 32'd469367,
        32'd234684, 32'd117342, 32'd58671, 32'd29335,
        32'd14668, 32'd7334, 32'd3667, 32'd1833,
        32'd917, 32'd458, 32'd229, 32'd115,
        32'd57, 32'd29, 32'd14, 32'd7,
        32'd4, 32'd2, 32'd1, 32'd0
    };

    // Per-item flags that ride along the angle pipeline.
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic degen;
        logic force90;
    } dau_flags_t;

endpackage

// ===== rtl/core/dihedral_angle_unit.sv =====
// Top level of the dihedral angle unit: bond vectors, dot and cross products, length and atan2.
//
//  Channel   Signals                                      Direction  Handshake
//  --------  -------------------------------------------  ---------  ----------------------
//  command   start, busy, first_x .. fourth_z             in         start & !busy
//  result    done, torsion_degrees, degenerate            out        done, one cycle
//
// A new transaction can be started in every clock cycle; busy is always low because
// the pipeline never holds back. Each transaction produces exactly one result, done
// is high for one cycle, and results leave in the order the commands came in.
// RW is the width of the bond length root, and the square root pipeline has one stage
// per root bit.
// Reset clears only the valid bits.
//
// Data flow: stage 1 forms the bond vectors a, b and c. Stage 2 registers the
// coordinate products of both cross products and of b.b. Stage 3 forms the two normals
// and |b|^2. The triple product T and the normal dot product Y come out of limb
// multipliers, while |b| with sixteen extra fraction bits comes out of the square
// root pipeline in parallel. T is delayed to meet the root, X = |b| * T is formed,
// Y is delayed to match, and the angle pipeline turns the pair into degrees.
module dihedral_angle_unit #(
    parameter int COORD_BITS   = 24,
    parameter int CORDIC_STEPS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          first_x,
    input  logic signed [COORD_BITS-1:0]          first_y,
    input  logic signed [COORD_BITS-1:0]          first_z,
    input  logic signed [COORD_BITS-1:0]          second_x,
    input  logic signed [COORD_BITS-1:0]          second_y,
    input  logic signed [COORD_BITS-1:0]          second_z,
    input  logic signed [COORD_BITS-1:0]          third_x,
    input  logic signed [COORD_BITS-1:0]          third_y,
    input  logic signed [COORD_BITS-1:0]          third_z,
    input  logic signed [COORD_BITS-1:0]          fourth_x,
    input  logic signed [COORD_BITS-1:0]          fourth_y,
    input  logic signed [COORD_BITS-1:0]          fourth_z,
    output logic                                  done,
    output logic signed [dau_pkg::ANGLE_BITS-1:0] torsion_degrees,
    output logic                                  degenerate
);
    import dau_pkg::*;

    // Widths of the exact integer arithmetic.
    localparam int DW  = COORD_BITS + 1;        // bond vector component
    localparam int PW  = 2 * DW;                // coordinate product
    localparam int CW  = PW + 1;                // cross product component
    localparam int TW  = DW + CW + 2;           // triple product T
    localparam int YW  = 2 * CW + 2;            // normal dot product Y
    localparam int BBW = PW + 2;                // |b|^2
    localparam int SW  = BBW - 1 + 2 * LEN_EXTRA;
    localparam int RW  = (SW + 1) / 2;          // root bits
    localparam int XW  = RW + 1 + TW;           // X = |b| * T
    localparam int Y2W = YW + LEN_EXTRA;        // Y scaled to match X
    localparam int VD  = 6 + RW;                // depth where X and Y meet

    logic [VD-1:0] vld_reg;

    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [DW-1:0] c_reg [3];

    logic signed [PW-1:0] pp1_reg [6];
    logic signed [PW-1:0] pp2_reg [6];
    logic signed [PW-1:0] sq_reg  [3];
    logic signed [DW-1:0] a2_reg  [3];

    logic signed [CW-1:0]  n1_reg [3];
    logic signed [CW-1:0]  n2_reg [3];
    logic signed [BBW-1:0] bb_reg;
    logic signed [DW-1:0]  a3_reg [3];

    logic signed [DW+CW-1:0] tp [3];
    logic signed [2*CW-1:0]  yp [3];
    logic signed [TW-1:0]    t_reg;
    logic signed [YW-1:0]    y_reg;

    logic [2*RW-1:0] rad;
    logic [RW-1:0]   root;
    logic [TW-1:0]   t_dly;
    logic [YW-1:0]   y_dly;

    logic signed [XW-1:0]  x_prod;
    logic signed [Y2W-1:0] y_scaled;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[VD-2:0], start && !busy};
        end
    end

    // Stage 1: bond vectors.
    always_ff @(posedge clk)
    begin
        a_reg[0] <= DW'(second_x) - DW'(first_x);
        a_reg[1] <= DW'(second_y) - DW'(first_y);
        a_reg[2] <= DW'(second_z) - DW'(first_z);
        b_reg[0] <= DW'(third_x) - DW'(second_x);
        b_reg[1] <= DW'(third_y) - DW'(second_y);
        b_reg[2] <= DW'(third_z) - DW'(second_z);
        c_reg[0] <= DW'(fourth_x) - DW'(third_x);
        c_reg[1] <= DW'(fourth_y) - DW'(third_y);
        c_reg[2] <= DW'(fourth_z) - DW'(third_z);
    end

    // Stage 2: the products that make up a x b, b x c and b.b.
    always_ff @(posedge clk)
    begin
        pp1_reg[0] <= a_reg[1] * b_reg[2];
        pp1_reg[1] <= a_reg[2] * b_reg[1];
        pp1_reg[2] <= a_reg[2] * b_reg[0];
        pp1_reg[3] <= a_reg[0] * b_reg[2];
        pp1_reg[4] <= a_reg[0] * b_reg[1];
        pp1_reg[5] <= a_reg[1] * b_reg[0];
        pp2_reg[0] <= b_reg[1] * c_reg[2];
        pp2_reg[1] <= b_reg[2] * c_reg[1];
        pp2_reg[2] <= b_reg[2] * c_reg[0];
        pp2_reg[3] <= b_reg[0] * c_reg[2];
        pp2_reg[4] <= b_reg[0] * c_reg[1];
        pp2_reg[5] <= b_reg[1] * c_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= b_reg[i] * b_reg[i];
            a2_reg[i] <= a_reg[i];
        end
    end

    // Stage 3: the two normals and the squared length of b.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_reg[i] <= CW'(pp1_reg[2*i]) - CW'(pp1_reg[2*i+1]);
            n2_reg[i] <= CW'(pp2_reg[2*i]) - CW'(pp2_reg[2*i+1]);
            a3_reg[i] <= a2_reg[i];
        end
        bb_reg <= BBW'(sq_reg[0]) + BBW'(sq_reg[1]) + BBW'(sq_reg[2]);
    end

    // Stages 4 to 6: the component products of T = a.(b x c) and Y = (a x b).(b x c).
    generate
        for (genvar i = 0; i < 3; i++) begin : g_dot
            dau_mul #(.WA(DW), .WB(CW)) u_tmul (
                .clk (clk),
                .a   (a3_reg[i]),
                .b   (n2_reg[i]),
                .p   (tp[i])
            );
            dau_mul #(.WA(CW), .WB(CW)) u_ymul (
                .clk (clk),
                .a   (n1_reg[i]),
                .b   (n2_reg[i]),
                .p   (yp[i])
            );
        end
    endgenerate

    // Stage 7: sum the components.
    always_ff @(posedge clk)
    begin
        t_reg <= TW'(tp[0]) + TW'(tp[1]) + TW'(tp[2]);
        y_reg <= YW'(yp[0]) + YW'(yp[1]) + YW'(yp[2]);
    end

    // |b| with sixteen extra fraction bits is floor(sqrt(|b|^2 * 2^32)).
    assign rad = (2*RW)'({bb_reg[BBW-2:0], {(2*LEN_EXTRA){1'b0}}});

    dau_sqrt #(.RW(RW)) u_sqrt (
        .clk  (clk),
        .rad  (rad),
        .root (root)
    );

    // T waits for the root; Y waits for the product X.
    dau_delay #(.W(TW), .N(RW - 4)) u_tdly (
        .clk (clk),
        .d   (t_reg),
        .q   (t_dly)
    );

    dau_delay #(.W(YW), .N(RW - 1)) u_ydly (
        .clk (clk),
        .d   (y_reg),
        .q   (y_dly)
    );

    dau_mul #(.WA(RW + 1), .WB(TW)) u_xmul (
        .clk (clk),
        .a   (signed'({1'b0, root})),
        .b   (signed'(t_dly)),
        .p   (x_prod)
    );

    assign y_scaled = signed'({y_dly, {LEN_EXTRA{1'b0}}});

    dau_angle #(.XW(XW), .YW(Y2W), .STEPS(CORDIC_STEPS)) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[VD-1]),
        .x         (x_prod),
        .y         (y_scaled),
        .out_valid (done),
        .angle     (torsion_degrees),
        .degen     (degenerate)
    );

    // A degenerate result always carries a zero angle.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> torsion_degrees == '0)
        else $error("degenerate result with nonzero angle");

    // Every angle lies within one half turn.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (torsion_degrees >= -ANGLE_MAX) && (torsion_degrees <= ANGLE_MAX))
        else $error("angle outside the half turn");

    // An accepted command enters the pipeline on the next edge.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> vld_reg[0])
        else $error("accepted command lost at pipeline entry");
endmodule

// ===== rtl/core/dau_delay.sv =====
// Fixed-length shift line that delays a payload word.
module dau_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    generate
        if (N == 0) begin : g_none
            assign q = d;
        end else begin : g_line
            logic [W-1:0] sh_reg [N];
            always_ff @(posedge clk)
            begin
                sh_reg[0] <= d;
                for (int k = 1; k < N; k++)
                begin
                    sh_reg[k] <= sh_reg[k-1];
                end
            end
            assign q = sh_reg[N-1];
        end
    endgenerate
endmodule

// ===== rtl/core/dau_mul.sv =====
// Signed multiplier split into limb partial products over three register stages.
module dau_mul #(
    parameter int WA = 25,
    parameter int WB = 51
) (
    input  logic                    clk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    import dau_pkg::*;

    localparam int L = MUL_LIMB;
    localparam int NA = (WA + L - 1) / L;
    localparam int NB = (WB + L - 1) / L;
    localparam int OW = WA + WB;

    logic signed [NA*L-1:0] a_ext;
    logic signed [NB*L-1:0] b_ext;
    logic signed [L:0]      la [NA];
    logic signed [L:0]      lb [NB];
    logic signed [2*L+1:0]  pp_reg [NA][NB];
    logic signed [OW-1:0]   row_reg [NA];
    logic signed [OW-1:0]   p_next;
    logic signed [OW-1:0]   p_reg;

    assign a_ext = (NA*L)'(a);
    assign b_ext = (NB*L)'(b);

    // The top limb carries the sign; lower limbs are unsigned.
    generate
        for (genvar i = 0; i < NA; i++) begin : g_la
            if (i == NA - 1) begin : g_top
                assign la[i] = (L+1)'(signed'(a_ext[i*L +: L]));
            end else begin : g_low
                assign la[i] = signed'({1'b0, a_ext[i*L +: L]});
            end
        end
        for (genvar j = 0; j < NB; j++) begin : g_lb
            if (j == NB - 1) begin : g_top
                assign lb[j] = (L+1)'(signed'(b_ext[j*L +: L]));
            end else begin : g_low
                assign lb[j] = signed'({1'b0, b_ext[j*L +: L]});
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= la[i] * lb[j];
            end
        end
    end

    generate
        for (genvar i = 0; i < NA; i++) begin : g_row
            logic signed [OW-1:0] row_sum;
            always_comb
            begin
                row_sum = '0;
                for (int j = 0; j < NB; j++)
                begin
                    row_sum = row_sum + (OW'(pp_reg[i][j]) <<< (j*L));
                end
            end
            always_ff @(posedge clk)
            begin
                row_reg[i] <= row_sum;
            end
        end
    endgenerate

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            p_next = p_next + (row_reg[i] <<< (i*L));
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

// ===== rtl/core/dau_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module dau_sqrt #(
    parameter int RW = 42
) (
    input  logic            clk,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);
    localparam int RMW = RW + 3;

    logic [RW-1:0]   root_reg [RW];
    logic [RMW-1:0]  rem_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];

    generate
        for (genvar k = 0; k < RW; k++) begin : g_stage
            logic [RW-1:0]   root_in;
            logic [RMW-1:0]  rem_in;
            logic [2*RW-1:0] rad_in;
            logic [RMW-1:0]  rem_sh;
            logic [RMW-1:0]  trial;

            if (k == 0) begin : g_first
                assign root_in = '0;
                assign rem_in  = '0;
                assign rad_in  = rad;
            end else begin : g_next
                assign root_in = root_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit.
            assign rem_sh = {rem_in[RMW-3:0], rad_in[2*RW-1 -: 2]};
            assign trial  = RMW'({root_in, 2'b01});

            always_ff @(posedge clk)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[RW-2:0], 1'b0};
                end
                rad_reg[k] <= {rad_in[2*RW-3:0], 2'b00};
            end
        end
    endgenerate

    assign root = root_reg[RW-1];
endmodule

// ===== rtl/core/dau_angle.sv =====
// Sign removal, normalization, CORDIC vectoring and degree rounding of atan2(x, y).
module dau_angle #(
    parameter int XW = 121,
    parameter int YW = 120,
    parameter int STEPS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [XW-1:0]               x,
    input  logic signed [YW-1:0]               y,
    output logic                               out_valid,
    output logic signed [dau_pkg::ANGLE_BITS-1:0] angle,
    output logic                               degen
);
    import dau_pkg::*;

    localparam int MW = (XW > YW) ? XW : YW;
    localparam int K = $clog2(MW);
    localparam int NS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
    localparam int NV = K + NS + 2;

    logic [NV-1:0] vld_reg;

    // Magnitude stage.
    logic signed [MW-1:0] sx;
    logic signed [MW-1:0] sy;
    logic [MW-1:0]        ax_reg;
    logic [MW-1:0]        ay_reg;
    dau_flags_t           af_reg;

    // Normalization stages.
    logic [MW-1:0] nx_reg [K];
    logic [MW-1:0] ny_reg [K];
    dau_flags_t    nf_reg [K];

    // Rotation stages.
    logic signed [UV_BITS-1:0] u_reg [NS];
    logic signed [UV_BITS-1:0] v_reg [NS];
    logic signed [Z_BITS-1:0]  z_reg [NS];
    dau_flags_t                cf_reg [NS];

    logic [NORM_BITS-1:0] un;
    logic [NORM_BITS-1:0] vn;
    dau_flags_t           f0;

    logic signed [Z_BITS-1:0]     zc;
    logic signed [Z_BITS-1:0]     theta;
    logic signed [Z_BITS-1:0]     q;
    logic signed [ANGLE_BITS-1:0] angle_next;
    logic signed [ANGLE_BITS-1:0] angle_reg;
    logic                         degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NV-2:0], in_valid};
        end
    end

    assign sx = MW'(x);
    assign sy = MW'(y);

    always_ff @(posedge clk)
    begin
        ax_reg         <= sx[MW-1] ? MW'(-sx) : sx;
        ay_reg         <= sy[MW-1] ? MW'(-sy) : sy;
        af_reg.xneg    <= sx[MW-1];
        af_reg.yneg    <= sy[MW-1];
        af_reg.degen   <= (sx == '0) && (sy == '0);
        af_reg.force90 <= 1'b0;
    end

    // Shift both magnitudes left together until the larger one has its top bit set.
    generate
        for (genvar k = 0; k < K; k++) begin : g_norm
            localparam int SH = 1 << (K - 1 - k);
            logic [MW-1:0] ix;
            logic [MW-1:0] iy;
            dau_flags_t    ifl;
            logic [MW-1:0] orv;

            if (k == 0) begin : g_first
                assign ix  = ax_reg;
                assign iy  = ay_reg;
                assign ifl = af_reg;
            end else begin : g_next
                assign ix  = nx_reg[k-1];
                assign iy  = ny_reg[k-1];
                assign ifl = nf_reg[k-1];
            end

            assign orv = ix | iy;

            always_ff @(posedge clk)
            begin
                if (orv[MW-1 -: SH] == '0)
                begin
                    nx_reg[k] <= ix << SH;
                    ny_reg[k] <= iy << SH;
                end
                else
                begin
                    nx_reg[k] <= ix;
                    ny_reg[k] <= iy;
                end
                nf_reg[k] <= ifl;
            end
        end
    endgenerate

    // Keeping the top bits equals a truncating right shift or a left shift to NORM_BITS.
    assign un = ny_reg[K-1][MW-1 -: NORM_BITS];
    assign vn = nx_reg[K-1][MW-1 -: NORM_BITS];

    always_comb
    begin
        f0         = nf_reg[K-1];
        f0.force90 = (un == '0) && (vn != '0);
    end

    generate
        for (genvar i = 0; i < NS; i++) begin : g_rot
            localparam logic signed [Z_BITS-1:0] ANG = signed'(Z_BITS'(ATAN_Q24[i]));
            logic signed [UV_BITS-1:0] iu;
            logic signed [UV_BITS-1:0] iv;
            logic signed [Z_BITS-1:0]  iz;
            dau_flags_t                ifl;
            logic signed [UV_BITS-1:0] du;
            logic signed [UV_BITS-1:0] dv;

            if (i == 0) begin : g_first
                assign iu  = signed'(UV_BITS'(un));
                assign iv  = signed'(UV_BITS'(vn));
                assign iz  = '0;
                assign ifl = f0;
            end else begin : g_next
                assign iu  = u_reg[i-1];
                assign iv  = v_reg[i-1];
                assign iz  = z_reg[i-1];
                assign ifl = cf_reg[i-1];
            end

            assign du = iv >>> i;
            assign dv = iu >>> i;

            always_ff @(posedge clk)
            begin
                if (iv > 0)
                begin
                    u_reg[i] <= iu + du;
                    v_reg[i] <= iv - dv;
                    z_reg[i] <= iz + ANG;
                end
                else if (iv < 0)
                begin
                    u_reg[i] <= iu - du;
                    v_reg[i] <= iv + dv;
                    z_reg[i] <= iz - ANG;
                end
                else
                begin
                    u_reg[i] <= iu;
                    v_reg[i] <= iv;
                    z_reg[i] <= iz;
                end
                cf_reg[i] <= ifl;
            end
        end
    endgenerate

    // Clamp, fold into the half turn by the sign of y, round to Q.16 and apply the sign of x.
    always_comb
    begin
        if (cf_reg[NS-1].force90)
        begin
            zc = DEG90_Q24;
        end
        else if (z_reg[NS-1] < 0)
        begin
            zc = '0;
        end
        else if (z_reg[NS-1] > DEG90_Q24)
        begin
            zc = DEG90_Q24;
        end
        else
        begin
            zc = z_reg[NS-1];
        end
        theta = cf_reg[NS-1].yneg ? (DEG180_Q24 - zc) : zc;
        q     = (theta + ROUND_HALF) >>> ROUND_SHIFT;
        if (cf_reg[NS-1].degen)
        begin
            angle_next = '0;
        end
        else if (cf_reg[NS-1].xneg)
        begin
            angle_next = ANGLE_BITS'(-q);
        end
        else
        begin
            angle_next = ANGLE_BITS'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        degen_reg <= cf_reg[NS-1].degen;
    end

    assign out_valid = vld_reg[NV-1];
    assign angle     = angle_reg;
    assign degen     = degen_reg;
endmodule
